// ----- hw/rtl/dense_object_table_with_id_recycling_unit_macros.svh -----
// assertion macros for the object table checker
`ifndef DENSE_OBJECT_TABLE_WITH_ID_RECYCLING_UNIT_MACROS_SVH
`define DENSE_OBJECT_TABLE_WITH_ID_RECYCLING_UNIT_MACROS_SVH

// same-cycle implication
`define DOT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/dotir_pkg.sv -----
// shared types and constants of the object table
`default_nettype none
package dotir_pkg;
   localparam int MAX_OBJECTS = 64;
   localparam int ID_W        = 6;
   localparam int SLOT_W      = 6;
   localparam int CNT_W       = 7;
   localparam int WORD_W      = 64;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_EXISTS = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NO_OBJ  = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   localparam logic [1:0] SEL_POS = 2'd0;
   localparam logic [1:0] SEL_VEL = 2'd1;
   localparam logic [1:0] SEL_ACC = 2'd2;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type mass;
      word_type radius;
      word_type pos_x;
      word_type pos_y;
      word_type pos_z;
      word_type vel_x;
      word_type vel_y;
      word_type vel_z;
      word_type acc_x;
      word_type acc_y;
      word_type acc_z;
   } row_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic look;
      logic fetch;
      logic exec;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_stall;
   } stat_type;
endpackage
`default_nettype wire

// ----- hw/rtl/dense_object_table_with_id_recycling_unit.sv -----
// object table: one word at a time, taken through capture, map lookup, row fetch and execute
// the result is registered at execute, which waits while the result port stalls
// the single-port row memory sets the steps: delete and read each need a map read then a row read
// a new word is taken in the capture cycle only; a waiting result does not block it
// synchronous reset clears counts, queue pointers and the per-id live bits; no clearing pass
`default_nettype none
module dense_object_table_with_id_recycling_unit import dotir_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   req_tuser,  // op
   input  wire logic [519:0] req_tdata,  // object_id, vector_select, mass_in, radius_in,
                                         // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [1:0]        rsp_tuser,  // status
   output logic [335:0]      rsp_tdata   // assigned_id, present, object_count, mass_out,
                                         // radius_out, vec_x, vec_y, vec_z, zero pad
);
   cmd_type  cmd;
   stat_type stat;

   // sequencer
   dotir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // storage and result path
   dotir_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
`default_nettype wire

// ----- hw/rtl/dotir_ctrl.sv -----
// sequencer for the object table: capture, lookup, fetch, execute
`default_nettype none
module dotir_ctrl import dotir_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_LOOK  = 4'b0010,
      S_FETCH = 4'b0100,
      S_EXEC  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_LOOK;
         S_LOOK:  state_in = S_FETCH;
         S_FETCH: state_in = S_EXEC;
         S_EXEC:  if (!stat.out_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // commands
   assign req_tready  = (state_ff == S_IDLE);
   assign cmd.capture = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.look    = (state_ff == S_LOOK);
   assign cmd.fetch   = (state_ff == S_FETCH);
   assign cmd.exec    = (state_ff == S_EXEC) && !stat.out_stall;
endmodule
`default_nettype wire

// ----- hw/rtl/dotir_datapath.sv -----
// maps, body rows, freed id queue and result register of the object table
`default_nettype none
module dotir_datapath import dotir_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cmd_type        cmd,
   output stat_type            stat,
   input  wire logic [1:0]     req_tuser,
   input  wire logic [519:0]   req_tdata,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [1:0]          rsp_tuser,
   output logic [335:0]        rsp_tdata
);
   // latched request word
   logic [1:0]   op_ff;
   logic [519:0] data_ff;
   logic [ID_W-1:0] id;
   logic [1:0]      vsel;
   assign id   = data_ff[5:0];
   assign vsel = data_ff[7:6];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_tuser;
         data_ff <= req_tdata;
      end
   end

   // control registers
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [ID_W-1:0]   head_ff, head_in, tail_ff, tail_in, fresh_ff, fresh_in;
   logic [MAX_OBJECTS-1:0] valid_ff, valid_in;

   // memories
   logic [SLOT_W-1:0] i2s_mem [MAX_OBJECTS];
   logic [ID_W-1:0]   s2i_mem [MAX_OBJECTS];
   logic [ID_W-1:0]   q_mem   [MAX_OBJECTS];
   row_type           row_mem [MAX_OBJECTS];
   logic [SLOT_W-1:0] i2s_rd;
   logic [ID_W-1:0]   s2i_rd, q_rd;
   row_type           row_rd;

   logic [SLOT_W-1:0] top;
   assign top = count_ff[SLOT_W-1:0] - 1'b1;

   // lookup reads
   always_ff @(posedge clock) begin
      if (cmd.look) begin
         i2s_rd <= i2s_mem[id];
         s2i_rd <= s2i_mem[top];
         q_rd   <= q_mem[head_ff];
      end
   end

   // row read: object slot for read, top slot for delete
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         row_rd <= row_mem[(op_ff == OP_READ) ? i2s_rd : top];
      end
   end

   // operation decode
   logic add_ok, del_ok, live, push, pop;
   logic [ID_W-1:0] nid;
   assign live   = valid_ff[id];
   assign add_ok = (op_ff == OP_ADD) && !count_ff[CNT_W-1];
   assign del_ok = (op_ff == OP_DELETE) && live;
   assign pop    = add_ok && (fill_ff != '0);
   assign push   = del_ok && !fill_ff[CNT_W-1];
   assign nid    = pop ? q_rd : fresh_ff;

   // new row for an add
   row_type add_row;
   always_comb begin
      add_row        = '0;
      add_row.mass   = data_ff[71:8];
      add_row.radius = data_ff[135:72];
      add_row.pos_x  = data_ff[199:136];
      add_row.pos_y  = data_ff[263:200];
      add_row.pos_z  = data_ff[327:264];
      add_row.vel_x  = data_ff[391:328];
      add_row.vel_y  = data_ff[455:392];
      add_row.vel_z  = data_ff[519:456];
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.exec && add_ok) begin
         row_mem[count_ff[SLOT_W-1:0]] <= add_row;
         i2s_mem[nid]                  <= count_ff[SLOT_W-1:0];
         s2i_mem[count_ff[SLOT_W-1:0]] <= nid;
      end else if (cmd.exec && del_ok) begin
         row_mem[i2s_rd] <= row_rd;
         i2s_mem[s2i_rd] <= i2s_rd;
         s2i_mem[i2s_rd] <= s2i_rd;
      end
      if (cmd.exec && push) begin
         q_mem[tail_ff] <= id;
      end
   end

   // next control state
   always_comb begin
      count_in = count_ff;
      fill_in  = fill_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fresh_in = fresh_ff;
      valid_in = valid_ff;
      if (add_ok) begin
         count_in      = count_ff + 1'b1;
         valid_in[nid] = 1'b1;
         if (pop) begin
            head_in = head_ff + 1'b1;
            fill_in = fill_ff - 1'b1;
         end else begin
            fresh_in = fresh_ff + 1'b1;
         end
      end else if (del_ok) begin
         count_in     = count_ff - 1'b1;
         valid_in[id] = 1'b0;
         if (push) begin
            tail_in = tail_ff + 1'b1;
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         fresh_ff <= '0;
         valid_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fresh_ff <= fresh_in;
         valid_ff <= valid_in;
      end
   end

   // result word
   status_type res_status;
   logic [ID_W-1:0] res_id;
   logic            res_present;
   word_type        res_mass, res_radius, res_x, res_y, res_z;
   always_comb begin
      res_status  = ST_OK;
      res_id      = '0;
      res_present = 1'b0;
      res_mass    = '0;
      res_radius  = '0;
      res_x       = '0;
      res_y       = '0;
      res_z       = '0;
      unique case (op_type'(op_ff))
         OP_ADD: begin
            if (add_ok) res_id = nid;
            else        res_status = ST_FULL;
         end
         OP_DELETE: begin
            if (!del_ok) res_status = ST_NO_OBJ;
         end
         OP_EXISTS: begin
            res_present = live;
         end
         OP_READ: begin
            if (!live) begin
               res_status = ST_NO_OBJ;
            end else begin
               res_present = 1'b1;
               res_mass    = row_rd.mass;
               res_radius  = row_rd.radius;
               case (vsel)
                  SEL_POS: begin
                     res_x = row_rd.pos_x; res_y = row_rd.pos_y; res_z = row_rd.pos_z;
                  end
                  SEL_VEL: begin
                     res_x = row_rd.vel_x; res_y = row_rd.vel_y; res_z = row_rd.vel_z;
                  end
                  SEL_ACC: begin
                     res_x = row_rd.acc_x; res_y = row_rd.acc_y; res_z = row_rd.acc_z;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // output register
   logic         rsp_tvalid_ff;
   logic [1:0]   rsp_tuser_ff;
   logic [335:0] rsp_tdata_ff;
   always_ff @(posedge clock) begin
      if (reset)                 rsp_tvalid_ff <= 1'b0;
      else if (cmd.exec)         rsp_tvalid_ff <= 1'b1;
      else if (rsp_tready)       rsp_tvalid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_tuser_ff <= res_status;
         rsp_tdata_ff <= {2'b00, res_z, res_y, res_x, res_radius, res_mass,
                          count_in, res_present, res_id};
      end
   end

   assign rsp_tvalid     = rsp_tvalid_ff;
   assign rsp_tuser      = rsp_tuser_ff;
   assign rsp_tdata      = rsp_tdata_ff;
   assign stat.out_stall = rsp_tvalid_ff && !rsp_tready;
endmodule
`default_nettype wire

// ----- hw/rtl/dotir_checker.sv -----
// port checker for the object table, bound to the top level
`default_nettype none
`include "dense_object_table_with_id_recycling_unit_macros.svh"
module dotir_checker import dotir_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [1:0]   rsp_tuser,
   input wire logic [335:0] rsp_tdata
);
   `DOT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result word dropped while stalled")
   `DOT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "word taken while one is in work")
   `DOT_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, rsp_tuser != ST_UNUSED, "unused status code")
   `DOT_ASSERT_NOW(a_full_count, clock, reset, rsp_tvalid && rsp_tuser == ST_FULL, rsp_tdata[13:7] == 7'd64, "table full reported below capacity")
endmodule

bind dense_object_table_with_id_recycling_unit dotir_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ----- bench/tb.sv -----
// self-checking bench for the dense object table with id recycling
`default_nettype none
module tb;
   import dotir_pkg::*;

   localparam int NUM_RANDOM = 470;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [1:0]   req_tuser;   // op
   logic [519:0] req_tdata;   // object_id, vector_select, mass_in, radius_in,
                              // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [1:0]   rsp_tuser;   // status
   logic [335:0] rsp_tdata;   // assigned_id, present, object_count, mass_out,
                              // radius_out, vec_x, vec_y, vec_z, zero pad

   typedef struct packed {
      logic [1:0]   op;
      logic [519:0] data;
   } word_in_type;

   typedef struct packed {
      logic [1:0]   status;
      logic [335:0] data;
   } word_out_type;

   word_in_type  pending_words[$];
   word_out_type expected_words[$];
   int           error_count;
   bit           stim_done;
   bit           hold_send;
   bit           req_accepted;

   // shadow copy of the table
   logic [6:0]  shadow_id_slot[MAX_OBJECTS];
   logic [5:0]  shadow_slot_id[MAX_OBJECTS];
   word_type    shadow_mass[MAX_OBJECTS];
   word_type    shadow_radius[MAX_OBJECTS];
   word_type    shadow_pos[MAX_OBJECTS][3];
   word_type    shadow_vel[MAX_OBJECTS][3];
   word_type    shadow_acc[MAX_OBJECTS][3];
   logic [5:0]  shadow_free_ids[MAX_OBJECTS];
   int          free_head, free_tail, free_fill, live_total, fresh_next;

   dense_object_table_with_id_recycling_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit id_live(logic [5:0] id);
      return shadow_id_slot[id] < MAX_OBJECTS;
   endfunction

   // work out the response of the table to one word and update the shadow
   function automatic word_out_type table_response(word_in_type w);
      word_out_type r;
      logic [5:0]   id, nid, top_id;
      logic [1:0]   sel;
      int           slot, top;
      logic         present;
      logic [5:0]   assigned;
      word_type     mo, ro, vx, vy, vz;
      id = w.data[5:0];
      sel = w.data[7:6];
      present = 1'b0; assigned = '0; mo = '0; ro = '0; vx = '0; vy = '0; vz = '0;
      r.status = ST_OK;
      case (op_type'(w.op))
         OP_ADD: begin
            if (live_total >= MAX_OBJECTS) begin
               r.status = ST_FULL;
            end else begin
               slot = live_total;
               live_total++;
               if (free_fill == 0) begin
                  nid = fresh_next[5:0];
                  fresh_next++;
               end else begin
                  nid = shadow_free_ids[free_head];
                  free_head = (free_head + 1) % MAX_OBJECTS;
                  free_fill--;
               end
               shadow_id_slot[nid] = 7'(slot);
               shadow_slot_id[slot] = nid;
               shadow_mass[slot] = w.data[8 +: 64];
               shadow_radius[slot] = w.data[72 +: 64];
               for (int k = 0; k < 3; k++) begin
                  shadow_pos[slot][k] = w.data[136 + 64*k +: 64];
                  shadow_vel[slot][k] = w.data[328 + 64*k +: 64];
                  shadow_acc[slot][k] = '0;
               end
               assigned = nid;
            end
         end
         OP_DELETE: begin
            if (!id_live(id) || live_total == 0) begin
               r.status = ST_NO_OBJ;
            end else begin
               slot = shadow_id_slot[id];
               top = live_total - 1;
               top_id = shadow_slot_id[top];
               shadow_mass[slot] = shadow_mass[top];
               shadow_radius[slot] = shadow_radius[top];
               shadow_pos[slot] = shadow_pos[top];
               shadow_vel[slot] = shadow_vel[top];
               shadow_acc[slot] = shadow_acc[top];
               shadow_id_slot[top_id] = 7'(slot);
               shadow_slot_id[slot] = top_id;
               shadow_id_slot[id] = 7'(MAX_OBJECTS);
               shadow_slot_id[top] = '0;
               if (free_fill < MAX_OBJECTS) begin
                  shadow_free_ids[free_tail] = id;
                  free_tail = (free_tail + 1) % MAX_OBJECTS;
                  free_fill++;
               end
               live_total--;
            end
         end
         OP_EXISTS: present = id_live(id);
         default: begin
            if (!id_live(id)) begin
               r.status = ST_NO_OBJ;
            end else begin
               slot = shadow_id_slot[id];
               present = 1'b1;
               mo = shadow_mass[slot];
               ro = shadow_radius[slot];
               if (sel == SEL_POS) begin
                  vx = shadow_pos[slot][0]; vy = shadow_pos[slot][1]; vz = shadow_pos[slot][2];
               end else if (sel == SEL_VEL) begin
                  vx = shadow_vel[slot][0]; vy = shadow_vel[slot][1]; vz = shadow_vel[slot][2];
               end else if (sel == SEL_ACC) begin
                  vx = shadow_acc[slot][0]; vy = shadow_acc[slot][1]; vz = shadow_acc[slot][2];
               end
            end
         end
      endcase
      r.data = {2'b00, vz, vy, vx, ro, mo, 7'(live_total), present, assigned};
      return r;
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic word_in_type make_word(op_type op, logic [5:0] id, logic [1:0] sel);
      word_in_type w;
      w.op = op;
      w.data = '0;
      w.data[5:0] = id;
      w.data[7:6] = sel;
      for (int k = 0; k < 8; k++) w.data[8 + 64*k +: 64] = rand_word();
      return w;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // stimulus: directed part then random phases of growth and shrinkage
   initial begin
      int add_bias;
      op_type op;
      for (int i = 0; i < MAX_OBJECTS; i++) shadow_id_slot[i] = 7'(MAX_OBJECTS);
      free_head = 0; free_tail = 0; free_fill = 0; live_total = 0; fresh_next = 0;
      error_count = 0; stim_done = 0; hold_send = 0;
      // empty table: unknown ids everywhere
      pending_words.push_back(make_word(OP_DELETE, 6'd0, 2'd0));
      pending_words.push_back(make_word(OP_READ, 6'd63, 2'd0));
      pending_words.push_back(make_word(OP_EXISTS, 6'd0, 2'd0));
      // extremes of the data words
      begin
         word_in_type w;
         w = make_word(OP_ADD, 6'd63, 2'd3); w.data[519:8] = '1; pending_words.push_back(w);
         w = make_word(OP_ADD, 6'd0, 2'd0); w.data[519:8] = '0; pending_words.push_back(w);
      end
      pending_words.push_back(make_word(OP_ADD, 6'd0, 2'd0));
      for (int s = 0; s < 4; s++) pending_words.push_back(make_word(OP_READ, 6'd0, 2'(s)));
      pending_words.push_back(make_word(OP_READ, 6'd1, 2'd1));
      pending_words.push_back(make_word(OP_EXISTS, 6'd2, 2'd0));
      // delete the bottom slot so the top is moved, then recycle
      pending_words.push_back(make_word(OP_DELETE, 6'd0, 2'd0));
      pending_words.push_back(make_word(OP_EXISTS, 6'd0, 2'd0));
      pending_words.push_back(make_word(OP_READ, 6'd2, 2'd0));
      pending_words.push_back(make_word(OP_DELETE, 6'd0, 2'd0));
      pending_words.push_back(make_word(OP_ADD, 6'd0, 2'd0));
      pending_words.push_back(make_word(OP_READ, 6'd0, 2'd2));
      // random phases: bias between add-heavy (fills the table) and delete-heavy
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 120 == 0) add_bias = (n / 120) % 2 ? 2 : 7;
         // quiet point: nothing more is sent until every result is back
         if (n == 60)
            wait (pending_words.size() == 0 && !req_tvalid && expected_words.size() == 0);
         if ($urandom_range(0, 9) < add_bias) op = OP_ADD;
         else op = op_type'($urandom_range(1, 3));
         // mostly ids that may be live
         pending_words.push_back(make_word(op,
            6'($urandom_range(0, 9) < 8 ? $urandom_range(0, 63) : $urandom_range(56, 63)),
            2'($urandom_range(0, 3))));
         if (n == 300) begin
            // flooding the table to the full case
            for (int k = 0; k < 70; k++) pending_words.push_back(make_word(OP_ADD, 6'd0, 2'd0));
         end
      end
      stim_done = 1;
   end

   // driver: one word per handshake, random gaps, at most one quiet pause
   initial begin
      int gap;
      bit paused;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tuser = '0; req_tdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      paused = 0;
      forever begin
         @(negedge clock);
         if (req_tvalid && !req_accepted) begin
            // keep presenting
         end else if (pending_words.size() > 0) begin
            gap = gap_length();
            if (req_tvalid) req_tvalid <= 1'b0;
            if (gap > 0) begin
               repeat (gap - 1) @(negedge clock);
               @(negedge clock);
            end
            if (!paused && stim_done == 0 && pending_words.size() < 400
                && expected_words.size() > 0 && gap > 0 && $urandom_range(0, 3) == 0) begin
               // hold off until the table has answered everything
               wait (expected_words.size() == 0);
               @(negedge clock);
               paused = 1;
            end
            req_tuser <= pending_words[0].op;
            req_tdata <= pending_words[0].data;
            req_tvalid <= 1'b1;
            void'(pending_words.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // record acceptance and predict
   always @(posedge clock) begin
      req_accepted <= 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         word_in_type w;
         w.op = req_tuser;
         w.data = req_tdata;
         expected_words.push_back(table_response(w));
         req_accepted <= 1'b1;
      end
   end

   // receiver stalls
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         gap = gap_length();
         if (gap == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   end

   // monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $display("%0t unexpected response status %0d data %h", $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            word_out_type e;
            e = expected_words.pop_front();
            if (e.status !== rsp_tuser) begin
               $display("%0t status expected %0d actual %0d", $time, e.status, rsp_tuser);
               error_count++;
            end
            if (e.data[5:0] !== rsp_tdata[5:0]) begin
               $display("%0t assigned_id expected %0d actual %0d",
                        $time, e.data[5:0], rsp_tdata[5:0]);
               error_count++;
            end
            if (e.data[6] !== rsp_tdata[6]) begin
               $display("%0t present expected %0d actual %0d", $time, e.data[6], rsp_tdata[6]);
               error_count++;
            end
            if (e.data[13:7] !== rsp_tdata[13:7]) begin
               $display("%0t object_count expected %0d actual %0d",
                        $time, e.data[13:7], rsp_tdata[13:7]);
               error_count++;
            end
            for (int k = 0; k < 5; k++) begin
               if (e.data[14 + 64*k +: 64] !== rsp_tdata[14 + 64*k +: 64]) begin
                  $display("%0t data word %0d expected %h actual %h", $time, k,
                           e.data[14 + 64*k +: 64], rsp_tdata[14 + 64*k +: 64]);
                  error_count++;
               end
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      wait (pending_words.size() == 0);
      @(posedge clock);
      while (req_tvalid) @(posedge clock);
      wait (expected_words.size() == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
